// File: src/knn_sorted_candidate_list_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted candidate list
// Shared concurrent checks, clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef KNN_SORTED_CANDIDATE_LIST_ASSERT_SVH
`define KNN_SORTED_CANDIDATE_LIST_ASSERT_SVH

// A condition that holds at every clock edge.
`define KNN_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// A consequence that holds in the same cycle as its trigger.
`define KNN_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that holds in the cycle after its trigger.
`define KNN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// Shared widths, register map, configuration and word types of the sorted
// candidate list.
// ----------------------------------------------------------------------------
package knn_pkg;

    // Field widths.
    localparam int DIST_W    = 50;
    localparam int ID_W      = 32;
    localparam int CFG_W     = 24;
    localparam int CFG_EXT_W = 32;
    localparam int LIMIT_W   = 7;
    localparam int RANK_W    = 6;

    // Configuration port.
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_EXCLUDED = 3'd4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd40;
    localparam logic [DIST_W-1:0]  DIST_MAX    = {DIST_W{1'b1}};

    // Configuration registers.
    typedef struct packed {
        logic [CFG_W-1:0]   center_x;
        logic [CFG_W-1:0]   center_y;
        logic [CFG_W-1:0]   center_z;
        logic [LIMIT_W-1:0] neighbour_limit;
        logic [ID_W-1:0]    excluded_id;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        center_x:        '0,
        center_y:        '0,
        center_z:        '0,
        neighbour_limit: LIMIT_RESET,
        excluded_id:     '0
    };

    // A candidate after the distance pipeline.
    typedef struct packed {
        logic              vld;
        logic              ins;
        logic              final_pt;
        logic [DIST_W-1:0] dsq;
        logic [ID_W-1:0]   id;
    } pt_word_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic              step;
        logic              ins;
        logic              rd_shift;
        logic [DIST_W-1:0] dsq;
        logic [ID_W-1:0]   id;
    } cell_ctrl_t;

    // Contents of one cell as seen by its neighbors.
    typedef struct packed {
        logic              occ;
        logic [DIST_W-1:0] dsq;
        logic [ID_W-1:0]   id;
    } cell_data_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

endpackage

// File: src/knn_regs.sv
// ----------------------------------------------------------------------------
// knn_regs
// APB-style configuration registers: query center, neighbor limit and the
// identifier of the query point.
// ----------------------------------------------------------------------------
module knn_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [knn_pkg::APB_AW-1:0]  paddr,
    input  logic [knn_pkg::APB_DW-1:0]  pwdata,
    output logic [knn_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output knn_pkg::cfg_t               cfg
);
    import knn_pkg::*;

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_AW-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CENTER_X: cfg_reg.center_x        <= pwdata[CFG_W-1:0];
                REG_CENTER_Y: cfg_reg.center_y        <= pwdata[CFG_W-1:0];
                REG_CENTER_Z: cfg_reg.center_z        <= pwdata[CFG_W-1:0];
                REG_LIMIT:    cfg_reg.neighbour_limit <= pwdata[LIMIT_W-1:0];
                REG_EXCLUDED: cfg_reg.excluded_id     <= pwdata[ID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (reg_idx)
            REG_CENTER_X: prdata = APB_DW'(cfg_reg.center_x);
            REG_CENTER_Y: prdata = APB_DW'(cfg_reg.center_y);
            REG_CENTER_Z: prdata = APB_DW'(cfg_reg.center_z);
            REG_LIMIT:    prdata = APB_DW'(cfg_reg.neighbour_limit);
            REG_EXCLUDED: prdata = APB_DW'(cfg_reg.excluded_id);
            default:      prdata = '0;
        endcase
    end

endmodule

// File: src/knn_dist.sv
// ----------------------------------------------------------------------------
// knn_dist
// Three-stage squared distance pipeline: absolute differences, squares, then
// a saturating sum. Also flags the query point itself.
// ----------------------------------------------------------------------------
module knn_dist #(
    parameter int COORD_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_vld,
    input  logic signed [COORD_BITS-1:0]  point_x,
    input  logic signed [COORD_BITS-1:0]  point_y,
    input  logic signed [COORD_BITS-1:0]  point_z,
    input  logic [knn_pkg::ID_W-1:0]      point_id,
    input  logic                          final_point,
    input  knn_pkg::cfg_t                 cfg,
    output knn_pkg::pt_word_t             pt
);
    import knn_pkg::*;

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 2;
    localparam int EXT_W = (SUM_W > DIST_W) ? SUM_W : DIST_W + 1;

    // Center coordinates, read as COORD_BITS-bit signed values.
    logic [CFG_EXT_W-1:0]          cx_ext, cy_ext, cz_ext;
    logic signed [COORD_BITS-1:0]  cx, cy, cz;
    logic signed [COORD_BITS:0]    dx, dy, dz;
    logic [COORD_BITS-1:0]         ax_next, ay_next, az_next;

    assign cx_ext = CFG_EXT_W'(cfg.center_x);
    assign cy_ext = CFG_EXT_W'(cfg.center_y);
    assign cz_ext = CFG_EXT_W'(cfg.center_z);
    assign cx     = signed'(cx_ext[COORD_BITS-1:0]);
    assign cy     = signed'(cy_ext[COORD_BITS-1:0]);
    assign cz     = signed'(cz_ext[COORD_BITS-1:0]);

    // Differences and their magnitudes.
    assign dx = {point_x[COORD_BITS-1], point_x} - {cx[COORD_BITS-1], cx};
    assign dy = {point_y[COORD_BITS-1], point_y} - {cy[COORD_BITS-1], cy};
    assign dz = {point_z[COORD_BITS-1], point_z} - {cz[COORD_BITS-1], cz};

    assign ax_next = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    assign ay_next = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    assign az_next = dz[COORD_BITS] ? COORD_BITS'(-dz) : COORD_BITS'(dz);

    // Stage A: magnitudes.
    logic                  a_vld_reg;
    logic [COORD_BITS-1:0] a_ax_reg, a_ay_reg, a_az_reg;
    logic [ID_W-1:0]       a_id_reg;
    logic                  a_ins_reg, a_final_reg;

    // Stage B: squares.
    logic                  b_vld_reg;
    logic [SQ_W-1:0]       b_sx_reg, b_sy_reg, b_sz_reg;
    logic [ID_W-1:0]       b_id_reg;
    logic                  b_ins_reg, b_final_reg;

    // Stage C: saturated distance.
    logic                  c_vld_reg;
    logic [DIST_W-1:0]     c_dist_reg;
    logic [ID_W-1:0]       c_id_reg;
    logic                  c_ins_reg, c_final_reg;

    logic [SQ_W-1:0]       sx_next, sy_next, sz_next;
    logic [EXT_W-1:0]      sum_next;
    logic [DIST_W-1:0]     dist_next;

    assign sx_next = SQ_W'(a_ax_reg) * SQ_W'(a_ax_reg);
    assign sy_next = SQ_W'(a_ay_reg) * SQ_W'(a_ay_reg);
    assign sz_next = SQ_W'(a_az_reg) * SQ_W'(a_az_reg);

    assign sum_next  = EXT_W'(b_sx_reg) + EXT_W'(b_sy_reg) + EXT_W'(b_sz_reg);
    assign dist_next = (sum_next > EXT_W'(DIST_MAX)) ? DIST_MAX : sum_next[DIST_W-1:0];

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    // Stage payloads advance every cycle.
    always_ff @(posedge aclk) begin
        a_ax_reg    <= ax_next;
        a_ay_reg    <= ay_next;
        a_az_reg    <= az_next;
        a_id_reg    <= point_id;
        a_ins_reg   <= (point_id != cfg.excluded_id);
        a_final_reg <= final_point;

        b_sx_reg    <= sx_next;
        b_sy_reg    <= sy_next;
        b_sz_reg    <= sz_next;
        b_id_reg    <= a_id_reg;
        b_ins_reg   <= a_ins_reg;
        b_final_reg <= a_final_reg;

        c_dist_reg  <= dist_next;
        c_id_reg    <= b_id_reg;
        c_ins_reg   <= b_ins_reg;
        c_final_reg <= b_final_reg;
    end

    assign pt = '{vld: c_vld_reg, ins: c_ins_reg, final_pt: c_final_reg,
                  dsq: c_dist_reg, id: c_id_reg};

endmodule

// File: src/knn_cell.sv
// ----------------------------------------------------------------------------
// knn_cell
// One slot of the sorted list. It compares the broadcast distance with its
// own entry and either keeps it, takes the new word, or takes its lower
// neighbor's entry; during readout it takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module knn_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  knn_pkg::cell_ctrl_t  ctrl,
    input  logic                 active,
    input  logic                 prev_ahead,
    input  knn_pkg::cell_data_t  low,
    input  knn_pkg::cell_data_t  high,
    output logic                 ahead,
    output knn_pkg::cell_data_t  q
);
    import knn_pkg::*;

    logic              occ_reg, occ_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic              occ_eff, take_new, take_low;

    // The new word goes after every entry whose distance is not larger.
    assign occ_eff  = occ_reg & active;
    assign ahead    = occ_eff & ~(ctrl.dsq < dist_reg);
    assign take_new = ctrl.ins & active & prev_ahead & ~ahead;
    assign take_low = ctrl.ins & active & ~prev_ahead;

    always_comb begin
        occ_next  = occ_reg;
        dist_next = dist_reg;
        id_next   = id_reg;
        if (ctrl.rd_shift) begin
            occ_next  = high.occ;
            dist_next = high.dsq;
            id_next   = high.id;
        end else if (ctrl.step) begin
            if (take_low) begin
                occ_next  = low.occ;
                dist_next = low.dsq;
                id_next   = low.id;
            end else if (take_new) begin
                occ_next  = 1'b1;
                dist_next = ctrl.dsq;
                id_next   = ctrl.id;
            end else begin
                // Slots at or past the limit are dropped here.
                occ_next  = occ_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg <= dist_next;
        id_reg   <= id_next;
    end

    assign q = '{occ: occ_reg, dsq: dist_reg, id: id_reg};

endmodule

// File: src/knn_sorted_candidate_list.sv
// ----------------------------------------------------------------------------
// knn_sorted_candidate_list
// Keeps the nearest candidate points to a configured center in a sorted row
// of cells and reads them out nearest first when the last point arrives.
//
// Input channel (s_*): one candidate point per word. Non-final words are
// taken one per cycle, back to back; each passes the magnitude, square
// and sum stages to the cell row, where all cells compare and shift at once.
// A word with s_final_point set is still inserted (unless it is the query
// point), after which s_ready stays low until the readout has been loaded.
// Result channel (m_*): after the final word leaves the distance stages,
// result words follow, one per cycle while m_ready is high, one per list
// entry, or a single word with m_found low if the list is empty.
// The readout rate is set by the cell row shifting down one slot per word.
// The output register lets s_ready rise again while the last word waits.
// A stalled receiver simply holds the readout; nothing is dropped.
// Configuration (APB-style, byte address 4 * index) may be written only
// while the block is idle. Reset empties the list and loads register
// defaults.
// ----------------------------------------------------------------------------
`include "knn_sorted_candidate_list_assert.svh"

module knn_sorted_candidate_list #(
    parameter int K_MAX      = 64,
    parameter int COORD_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [knn_pkg::APB_AW-1:0]     paddr,
    input  logic [knn_pkg::APB_DW-1:0]     pwdata,
    output logic [knn_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [COORD_BITS-1:0]   s_point_x,
    input  logic signed [COORD_BITS-1:0]   s_point_y,
    input  logic signed [COORD_BITS-1:0]   s_point_z,
    input  logic [knn_pkg::ID_W-1:0]       s_point_id,
    input  logic                           s_final_point,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [knn_pkg::ID_W-1:0]       m_neighbour_id,
    output logic [knn_pkg::DIST_W-1:0]     m_neighbour_dist_sq,
    output logic [knn_pkg::RANK_W-1:0]     m_rank,
    output logic                           m_found,
    output logic                           m_last_result
);
    import knn_pkg::*;

    cfg_t               cfg;
    pt_word_t           pt;
    cell_ctrl_t         ctrl;
    logic [LIMIT_W-1:0] lim;
    logic               s_acc;

    // Configuration registers.
    knn_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Effective neighbor limit, clamped to one and K_MAX.
    always_comb begin
        if (cfg.neighbour_limit == '0) begin
            lim = LIMIT_W'(1);
        end else if (cfg.neighbour_limit > LIMIT_W'(K_MAX)) begin
            lim = LIMIT_W'(K_MAX);
        end else begin
            lim = cfg.neighbour_limit;
        end
    end

    assign s_acc = s_valid & s_ready;

    // Distance pipeline.
    knn_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_vld      (s_acc),
        .point_x     (s_point_x),
        .point_y     (s_point_y),
        .point_z     (s_point_z),
        .point_id    (s_point_id),
        .final_point (s_final_point),
        .cfg         (cfg),
        .pt          (pt)
    );

    // Readout control.
    state_t            state_reg, state_next;
    logic              hold_reg, hold_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic              load, last_now, shift_rd;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [ID_W-1:0]   m_id_reg;
    logic [DIST_W-1:0] m_dist_reg;
    logic [RANK_W-1:0] m_rank_reg;
    logic              m_found_reg, m_last_result_reg;

    // Cell row.
    cell_data_t        cell_q [K_MAX];
    logic [K_MAX-1:0]  ahead_vec, active_vec, occ_vec;
    logic [K_MAX:0]    occ_x;

    assign occ_x    = {1'b0, occ_vec};
    assign last_now = ~occ_x[0] | ~occ_x[1];
    assign shift_rd = load & occ_x[0];

    assign ctrl = '{step: pt.vld, ins: pt.vld & pt.ins, rd_shift: shift_rd,
                    dsq: pt.dsq, id: pt.id};

    for (genvar g = 0; g < K_MAX; g++) begin : g_cell
        cell_data_t low_d, high_d;
        logic       prev_b;

        if (g == 0) begin : g_first
            assign low_d  = '0;
            assign prev_b = 1'b1;
        end else begin : g_rest
            assign low_d  = cell_q[g-1];
            assign prev_b = ahead_vec[g-1];
        end

        if (g == K_MAX - 1) begin : g_top
            assign high_d = '0;
        end else begin : g_below
            assign high_d = cell_q[g+1];
        end

        assign active_vec[g] = (LIMIT_W'(g) < lim);
        assign occ_vec[g]    = cell_q[g].occ;

        knn_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .active      (active_vec[g]),
            .prev_ahead  (prev_b),
            .low         (low_d),
            .high        (high_d),
            .ahead       (ahead_vec[g]),
            .q           (cell_q[g])
        );
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pt.vld && pt.final_pt) begin
                    state_next = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (load && last_now) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs: in ST_DUMP, load when the output register is free or taken.
    always_comb begin
        load = 1'b0;
        unique case (state_reg)
            ST_IDLE: load = 1'b0;
            ST_DUMP: load = ~m_valid_reg | m_ready;
            default: load = 1'b0;
        endcase
    end

    // Input is held off from a final word until its readout is loaded.
    always_comb begin
        hold_next = hold_reg;
        if (s_acc && s_final_point) begin
            hold_next = 1'b1;
        end else if (load && last_now) begin
            hold_next = 1'b0;
        end
    end

    always_comb begin
        rank_next = rank_reg;
        if (load) begin
            rank_next = last_now ? '0 : rank_reg + 1'b1;
        end
    end

    assign s_ready = ~hold_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            hold_reg    <= 1'b0;
            rank_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hold_reg    <= hold_next;
            rank_reg    <= rank_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_id_reg          <= occ_x[0] ? cell_q[0].id : '0;
            m_dist_reg        <= occ_x[0] ? cell_q[0].dsq : '0;
            m_rank_reg        <= rank_reg;
            m_found_reg       <= occ_x[0];
            m_last_result_reg <= last_now;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_neighbour_id      = m_id_reg;
    assign m_neighbour_dist_sq = m_dist_reg;
    assign m_rank              = m_rank_reg;
    assign m_found             = m_found_reg;
    assign m_last_result       = m_last_result_reg;

    // Checks.
    logic [K_MAX:0] occ_sum;
    assign occ_sum = occ_x + (K_MAX + 1)'(1);

    `KNN_ASSERT_ALWAYS(a_occ_contig, $onehot(occ_sum), "cell occupancy is not contiguous")
    `KNN_ASSERT_IMPLIES(a_dump_closed, state_reg == ST_DUMP, !s_ready && !pt.vld, "input open")
    `KNN_ASSERT_NEXT(a_last_ends, load && last_now, state_reg == ST_IDLE && s_ready, "no end")
    `KNN_ASSERT_IMPLIES(a_empty_word, m_valid && !m_found, m_last_result && m_rank == '0, "bad")

endmodule
